// ----- rtl/s256h_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package s256h_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COMP,
		ST_FOLD,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_PAD80,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      push;
		byte_sel_t sel;
		logic      len_inc;
		logic      load_vars;
		logic      round;
		logic      fold;
		logic      out_adv;
		logic      clear;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt63;
		logic cnt56;
		logic round_last;
		logic len_last;
		logic word_last;
	} dp_stat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] PAD_STOP = 6'd56;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] K_ROUND [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ----- rtl/s256h_ctrl.sv -----
// Controller state machine: byte intake, padding sequence, round loop and digest output.
module s256h_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_present,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  s256h_pkg::dp_stat_t stat,
	output s256h_pkg::dp_cmd_t  cmd
);

	s256h_pkg::state_t state_q, state_d;
	s256h_pkg::state_t ret_q, ret_d;
	logic in_acc;
	logic out_acc;

	assign in_acc  = in_valid && (state_q == s256h_pkg::ST_IDLE);
	assign out_acc = out_ready && (state_q == s256h_pkg::ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= s256h_pkg::ST_IDLE;
			ret_q   <= s256h_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			s256h_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_present && stat.cnt63) begin
						state_d = s256h_pkg::ST_COMP;
						ret_d   = in_last ? s256h_pkg::ST_PAD80 : s256h_pkg::ST_IDLE;
					end else if (in_last) begin
						state_d = s256h_pkg::ST_PAD80;
					end
				end
			end
			s256h_pkg::ST_COMP: begin
				if (stat.round_last) state_d = s256h_pkg::ST_FOLD;
			end
			s256h_pkg::ST_FOLD: begin
				state_d = ret_q;
			end
			s256h_pkg::ST_PAD80: begin
				if (stat.cnt63) begin
					state_d = s256h_pkg::ST_COMP;
					ret_d   = s256h_pkg::ST_PADZ;
				end else begin
					state_d = s256h_pkg::ST_PADZ;
				end
			end
			s256h_pkg::ST_PADZ: begin
				if (stat.cnt56) begin
					state_d = s256h_pkg::ST_PADLEN;
				end else if (stat.cnt63) begin
					state_d = s256h_pkg::ST_COMP;
					ret_d   = s256h_pkg::ST_PADZ;
				end
			end
			s256h_pkg::ST_PADLEN: begin
				if (stat.len_last) begin
					state_d = s256h_pkg::ST_COMP;
					ret_d   = s256h_pkg::ST_OUT;
				end
			end
			s256h_pkg::ST_OUT: begin
				if (out_acc && stat.word_last) state_d = s256h_pkg::ST_IDLE;
			end
			default: begin
				state_d = s256h_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.sel   = s256h_pkg::SEL_DATA;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			s256h_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.push    = in_acc && in_present;
				cmd.len_inc = in_acc && in_present;
			end
			s256h_pkg::ST_COMP: begin
				cmd.round = 1'b1;
			end
			s256h_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			s256h_pkg::ST_PAD80: begin
				cmd.push = 1'b1;
				cmd.sel  = s256h_pkg::SEL_PAD80;
			end
			s256h_pkg::ST_PADZ: begin
				cmd.push = !stat.cnt56;
				cmd.sel  = s256h_pkg::SEL_ZERO;
			end
			s256h_pkg::ST_PADLEN: begin
				cmd.push = 1'b1;
				cmd.sel  = s256h_pkg::SEL_LEN;
			end
			s256h_pkg::ST_OUT: begin
				out_valid   = 1'b1;
				cmd.out_adv = out_acc;
				cmd.clear   = out_acc && stat.word_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
		cmd.load_vars = cmd.push && stat.cnt63;
	end

endmodule

// ----- rtl/s256h_dp.sv -----
// Datapath: block/schedule shift line, working variables, chaining value and counters.
module s256h_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  s256h_pkg::dp_cmd_t  cmd,
	input  logic [7:0]          in_byte,
	output s256h_pkg::dp_stat_t stat,
	output logic [31:0]         digest_word,
	output logic [2:0]          word_index
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] cv_q [8];
	logic [60:0] len_q;
	logic [5:0]  cnt_q;
	logic [5:0]  round_q;
	logic [2:0]  pidx_q;
	logic [2:0]  oidx_q;

	logic [63:0] bits;
	logic [7:0]  push_byte;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;

	assign bits = {len_q, 3'b000};

	always_comb begin
		case (cmd.sel)
			s256h_pkg::SEL_DATA:  push_byte = in_byte;
			s256h_pkg::SEL_PAD80: push_byte = s256h_pkg::PAD_BYTE;
			s256h_pkg::SEL_ZERO:  push_byte = 8'h00;
			s256h_pkg::SEL_LEN:   push_byte = bits[{3'd7 - pidx_q, 3'b000} +: 8];
			default:              push_byte = 8'h00;
		endcase
	end

	assign w_new = s256h_pkg::small_s1(w_q[14]) + w_q[9] + s256h_pkg::small_s0(w_q[1]) + w_q[0];
	assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1    = v_q[7] + s256h_pkg::big_s1(v_q[4]) + ch + s256h_pkg::K_ROUND[round_q] + w_q[0];
	assign t2    = s256h_pkg::big_s0(v_q[0]) + mj;

	// message bytes shift in at the bottom; rounds consume words from the top
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], push_byte};
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= cv_q[i];
			end
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				cv_q[i] <= s256h_pkg::IV[i];
			end
			len_q   <= '0;
			cnt_q   <= '0;
			round_q <= '0;
			pidx_q  <= '0;
			oidx_q  <= '0;
		end else begin
			if (cmd.clear) begin
				for (int i = 0; i < 8; i++) begin
					cv_q[i] <= s256h_pkg::IV[i];
				end
			end else if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					cv_q[i] <= cv_q[i] + v_q[i];
				end
			end
			if (cmd.clear) begin
				len_q <= '0;
			end else if (cmd.len_inc) begin
				len_q <= len_q + 61'd1;
			end
			if (cmd.push) cnt_q <= cnt_q + 6'd1;
			if (cmd.load_vars) begin
				round_q <= '0;
			end else if (cmd.round) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.push && cmd.sel == s256h_pkg::SEL_LEN) pidx_q <= pidx_q + 3'd1;
			if (cmd.out_adv) oidx_q <= oidx_q + 3'd1;
		end
	end

	assign stat.cnt63      = (cnt_q == 6'd63);
	assign stat.cnt56      = (cnt_q == s256h_pkg::PAD_STOP);
	assign stat.round_last = (round_q == 6'd63);
	assign stat.len_last   = (pidx_q == 3'd7);
	assign stat.word_last  = (oidx_q == 3'd7);

	assign digest_word = cv_q[oidx_q];
	assign word_index  = oidx_q;

endmodule

// ----- rtl/sha256_byte_stream_hasher_core.sv -----
// Top level of the SHA-256 byte stream hasher: stream ports, controller and datapath.
// Intake: one byte per cycle; the 64th byte of a block stalls intake until the block is compressed
// (64 rounds on the single round unit, then a fold into the chaining value).
// Finish: the 0x80 byte, zero bytes up to offset 56, a check state, the 8 length bytes
// and a compression per filled block (final one included), then 8 digest transactions.
// One message at a time; no new byte is taken until the last digest word is taken.
// arst_n low clears all control state and loads the initial chaining value.
module sha256_byte_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] byte_present
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);

	s256h_pkg::dp_cmd_t  cmd;
	s256h_pkg::dp_stat_t stat;

	s256h_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_present (s_axis_tuser),
		.in_last    (s_axis_tlast),
		.in_ready   (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	s256h_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_byte     (s_axis_tdata),
		.stat        (stat),
		.digest_word (m_axis_tdata),
		.word_index  (m_axis_tuser)
	);

	assign m_axis_tlast = stat.word_last;

endmodule

// ----- rtl/s256h_chk.sv -----
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
module s256h_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("intake open while digest is emitted");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
		else $error("tlast does not mark word seven");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
		else $error("digest words out of sequence");

	a_digest_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("extra digest transaction");

	a_finish_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("intake open right after message end");

endmodule

bind sha256_byte_stream_hasher_core s256h_chk u_s256h_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
